@@ rtl/nnbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnbs_pkg: shared constants, codes and types of the blit scaler
// Field widths, command and status codes, divider request and response.
// ----------------------------------------------------------------------------
package nnbs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_DIM   = 4096;
  localparam int SPAN_W    = 13;
  localparam int ORG_W     = 12;
  localparam int SRC_W     = 13;
  localparam int DST_W     = 12;
  localparam int PIX_W     = 32;
  localparam int ACC_W     = 32;
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);
  localparam int DVD_W     = SPAN_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int MODE_W    = 2;
  localparam int PAIR_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 16;

  // commands
  localparam logic [MODE_W-1:0] MODE_PAL_WR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NEXT    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CONVERT = 2'd3;

  // format pairs
  localparam logic [PAIR_W-1:0] PAIR_IDX_IDX   = 2'd0;
  localparam logic [PAIR_W-1:0] PAIR_ARGB_ARGB = 2'd1;
  localparam logic [PAIR_W-1:0] PAIR_IDX_ARGB  = 2'd2;
  localparam logic [PAIR_W-1:0] PAIR_ARGB_IDX  = 2'd3;

  // status
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_PAIR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_BLIT  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_SRC_W    = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_SRC_H    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_DST_W    = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_DST_H    = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_PAIR     = 3'd6;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [SPAN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [SPAN_W-1:0] clamp_dim(input logic [SPAN_W-1:0] v);
    return (v > SPAN_W'(MAX_DIM)) ? SPAN_W'(MAX_DIM) : v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/nnbs_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnbs_if: channel interfaces of the blit scaler
// Command input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface nnbs_in_if
  import nnbs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [7:0]        palette_slot;
  logic [PIX_W-1:0]  palette_color;
  logic [PIX_W-1:0]  pixel_in;

  modport source (output valid, mode, palette_slot, palette_color, pixel_in,
                  input ready);
  modport sink   (input valid, mode, palette_slot, palette_color, pixel_in,
                  output ready);
endinterface

interface nnbs_out_if
  import nnbs_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SRC_W-1:0]    src_col;
  logic [SRC_W-1:0]    src_row;
  logic [DST_W-1:0]    dst_col;
  logic [DST_W-1:0]    dst_row;
  logic [PIX_W-1:0]    pixel_out;
  logic                last;
  logic [STATUS_W-1:0] status;

  modport source (output valid, src_col, src_row, dst_col, dst_row, pixel_out, last,
                  status, input ready);
  modport sink   (input valid, src_col, src_row, dst_col, dst_row, pixel_out, last,
                  status, output ready);
endinterface

interface nnbs_cfg_if
  import nnbs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

@@ rtl/nnbs_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnbs_divider: shared restoring divider
// One quotient bit per cycle; done pulses, registered together with the final quotient.
// ----------------------------------------------------------------------------
module nnbs_divider
  import nnbs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SPAN_W:0]      rem_r, rem_nxt;
  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [SPAN_W-1:0]    dsr_r, dsr_nxt;
  logic [SPAN_W:0]      trial;
  logic                 fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_r[SPAN_W-1:0], quo_r[DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? (trial - {1'b0, dsr_r}) : trial;
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

@@ rtl/nnbs_palette.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnbs_palette: color lookup memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nnbs_palette
  import nnbs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [PAL_AW-1:0] wr_addr,
  input  wire logic [PIX_W-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [PAL_AW-1:0] rd_addr,
  output logic      [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [PAL_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/nearest_neighbor_blit_scaler_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_blit_scaler_core: nearest-neighbor blit stepper
// Walks a destination rectangle row-major and names the source pixel that
// each destination pixel samples; also converts pixels through a palette.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   mode, palette_slot, palette_color, pixel_in
//  out_ch   out  valid/ready   src_col, src_row, dst_col, dst_row, pixel_out,
//                              last, status
//  cfg_ch   in   valid/ready   addr (register index), data
//
//  Palette write, next coordinate, and pass-through convert: handled in idle.
//  Palette convert: goes through S_PAL (registered palette read).
//  Start blit: the shared restoring divider computes step_x then step_y,
//  one quotient bit per cycle.
//  Input is taken only while the sequencer is idle and the result register
//  is empty or being drained in the same cycle. Reset is synchronous: it
//  clears config, steps, counters and active; palette contents stay unknown.
// ----------------------------------------------------------------------------
module nearest_neighbor_blit_scaler_core
  import nnbs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  nnbs_in_if.sink     in_ch,
  nnbs_out_if.source  out_ch,
  nnbs_cfg_if.sink    cfg_ch
);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV_X = 2'd1;
  localparam logic [1:0] S_DIV_Y = 2'd2;
  localparam logic [1:0] S_PAL   = 2'd3;

  // configuration registers
  logic [ORG_W-1:0]  org_x_r, org_y_r;
  logic [SPAN_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [PAIR_W-1:0] pair_r;

  // blit state
  logic [1:0]        state_r, state_nxt;
  logic [ACC_W-1:0]  step_x_r, step_x_nxt, step_y_r, step_y_nxt;
  logic [ACC_W-1:0]  acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic [SPAN_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic              active_r, active_nxt;

  // result register
  logic                out_valid_r, out_valid_nxt;
  logic [SRC_W-1:0]    o_src_col_r, o_src_col_nxt, o_src_row_r, o_src_row_nxt;
  logic [DST_W-1:0]    o_dst_col_r, o_dst_col_nxt, o_dst_row_r, o_dst_row_nxt;
  logic [PIX_W-1:0]    o_pix_r, o_pix_nxt;
  logic                o_last_r, o_last_nxt;
  logic [STATUS_W-1:0] o_status_r, o_status_nxt;

  // result staging
  logic                emit;
  logic [SRC_W-1:0]    e_src_col, e_src_row;
  logic [DST_W-1:0]    e_dst_col, e_dst_row;
  logic [PIX_W-1:0]    e_pix;
  logic                e_last;
  logic [STATUS_W-1:0] e_status;

  logic              accept;
  logic [SPAN_W-1:0] tw, th, sw, sh;
  logic [SPAN_W:0]   col_inc, row_inc;
  logic              is_last;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              pal_we, pal_re;
  logic [PIX_W-1:0]  pal_rdata;

  assign tw = clamp_dim(dst_w_r);
  assign th = clamp_dim(dst_h_r);
  assign sw = clamp_dim(src_w_r);
  assign sh = clamp_dim(src_h_r);

  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;
  assign is_last = (col_inc >= {1'b0, tw}) && (row_inc >= {1'b0, th});

  // take a command only when idle and the result slot is free this cycle
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // config is always accepted
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    step_x_nxt    = step_x_r;
    step_y_nxt    = step_y_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    active_nxt    = active_r;
    div_req.start = 1'b0;
    // the divider runs x first (started from idle), then y
    div_req.dividend = (state_r == S_IDLE) ? {sw, FRAC_BITS'(0)}
                                           : {sh, FRAC_BITS'(0)};
    div_req.divisor  = (state_r == S_IDLE) ? tw : th;
    pal_we        = 1'b0;
    pal_re        = 1'b0;
    emit          = 1'b0;
    e_src_col     = '0;
    e_src_row     = '0;
    e_dst_col     = '0;
    e_dst_row     = '0;
    e_pix         = '0;
    e_last        = 1'b0;
    e_status      = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.mode)
            MODE_PAL_WR: begin
              pal_we = 1'b1;
            end
            MODE_START: begin
              active_nxt = 1'b0;
              col_nxt    = '0;
              row_nxt    = '0;
              acc_x_nxt  = '0;
              acc_y_nxt  = ACC_W'(org_y_r) << FRAC_BITS;
              if (pair_r == PAIR_ARGB_IDX) begin
                emit     = 1'b1;
                e_status = ST_BAD_PAIR;
              end else if (tw != '0 && th != '0) begin
                div_req.start = 1'b1;
                state_nxt     = S_DIV_X;
              end
            end
            MODE_NEXT: begin
              emit = 1'b1;
              if (!active_r) begin
                e_status = ST_NO_BLIT;
              end else begin
                e_src_col = SRC_W'(SRC_W'(org_x_r) + acc_x_r[FRAC_BITS +: SRC_W]);
                e_src_row = acc_y_r[FRAC_BITS +: SRC_W];
                e_dst_col = col_r[DST_W-1:0];
                e_dst_row = row_r[DST_W-1:0];
                e_last    = is_last;
                if (is_last) begin
                  active_nxt = 1'b0;
                end else if (col_inc >= {1'b0, tw}) begin
                  // wrap to the start of the next row
                  col_nxt   = '0;
                  acc_x_nxt = '0;
                  row_nxt   = row_inc[SPAN_W-1:0];
                  acc_y_nxt = acc_y_r + step_y_r;
                end else begin
                  col_nxt   = col_inc[SPAN_W-1:0];
                  acc_x_nxt = acc_x_r + step_x_r;
                end
              end
            end
            MODE_CONVERT: begin
              case (pair_r)
                PAIR_IDX_IDX: begin
                  emit  = 1'b1;
                  e_pix = {{(PIX_W-8){1'b0}}, in_ch.pixel_in[7:0]};
                end
                PAIR_ARGB_ARGB: begin
                  emit  = 1'b1;
                  e_pix = in_ch.pixel_in;
                end
                PAIR_IDX_ARGB: begin
                  pal_re    = 1'b1;
                  state_nxt = S_PAL;
                end
                default: begin
                  emit     = 1'b1;
                  e_status = ST_BAD_PAIR;
                end
              endcase
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV_X: begin
        if (div_rsp.done) begin
          step_x_nxt    = ACC_W'(div_rsp.quotient);
          div_req.start = 1'b1;
          state_nxt     = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        if (div_rsp.done) begin
          step_y_nxt = ACC_W'(div_rsp.quotient);
          active_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_PAL: begin
        emit      = 1'b1;
        e_pix     = pal_rdata;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register: drained by out_ch.ready, refilled by emit
  always_comb begin
    out_valid_nxt = out_valid_r;
    o_src_col_nxt = o_src_col_r;
    o_src_row_nxt = o_src_row_r;
    o_dst_col_nxt = o_dst_col_r;
    o_dst_row_nxt = o_dst_row_r;
    o_pix_nxt     = o_pix_r;
    o_last_nxt    = o_last_r;
    o_status_nxt  = o_status_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      o_src_col_nxt = e_src_col;
      o_src_row_nxt = e_src_row;
      o_dst_col_nxt = e_dst_col;
      o_dst_row_nxt = e_dst_row;
      o_pix_nxt     = e_pix;
      o_last_nxt    = e_last;
      o_status_nxt  = e_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r     <= '0;
      org_y_r     <= '0;
      src_w_r     <= '0;
      src_h_r     <= '0;
      dst_w_r     <= '0;
      dst_h_r     <= '0;
      pair_r      <= PAIR_IDX_IDX;
      state_r     <= S_IDLE;
      step_x_r    <= '0;
      step_y_r    <= '0;
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      col_r       <= '0;
      row_r       <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.addr)
          CFG_ORIGIN_X: org_x_r <= cfg_ch.data[ORG_W-1:0];
          CFG_ORIGIN_Y: org_y_r <= cfg_ch.data[ORG_W-1:0];
          CFG_SRC_W:    src_w_r <= cfg_ch.data[SPAN_W-1:0];
          CFG_SRC_H:    src_h_r <= cfg_ch.data[SPAN_W-1:0];
          CFG_DST_W:    dst_w_r <= cfg_ch.data[SPAN_W-1:0];
          CFG_DST_H:    dst_h_r <= cfg_ch.data[SPAN_W-1:0];
          CFG_PAIR:     pair_r  <= cfg_ch.data[PAIR_W-1:0];
          default: begin
          end
        endcase
      end
      state_r     <= state_nxt;
      step_x_r    <= step_x_nxt;
      step_y_r    <= step_y_nxt;
      acc_x_r     <= acc_x_nxt;
      acc_y_r     <= acc_y_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
    o_src_col_r <= o_src_col_nxt;
    o_src_row_r <= o_src_row_nxt;
    o_dst_col_r <= o_dst_col_nxt;
    o_dst_row_r <= o_dst_row_nxt;
    o_pix_r     <= o_pix_nxt;
    o_last_r    <= o_last_nxt;
    o_status_r  <= o_status_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.src_col   = o_src_col_r;
  assign out_ch.src_row   = o_src_row_r;
  assign out_ch.dst_col   = o_dst_col_r;
  assign out_ch.dst_row   = o_dst_row_r;
  assign out_ch.pixel_out = o_pix_r;
  assign out_ch.last      = o_last_r;
  assign out_ch.status    = o_status_r;

  nnbs_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  nnbs_palette u_palette (
    .clk     (clk),
    .wr_en   (pal_we),
    .wr_addr (in_ch.palette_slot),
    .wr_data (in_ch.palette_color),
    .rd_en   (pal_re),
    .rd_addr (in_ch.pixel_in[PAL_AW-1:0]),
    .rd_data (pal_rdata)
  );

endmodule
`default_nettype wire

@@ verif/blit_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blit_result_checker: result predictor and comparator for the blit scaler
// Follows every command, result and register transfer, keeps its own copy of
// the stepper and palette state, and checks each result field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module blit_result_checker
  import nnbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  nnbs_in_if   in_ch,
  nnbs_out_if  out_ch,
  nnbs_cfg_if  cfg_ch,
  output int   fail_count,
  output int   outstanding
);

  typedef struct packed {
    logic [SRC_W-1:0]    src_col;
    logic [SRC_W-1:0]    src_row;
    logic [DST_W-1:0]    dst_col;
    logic [DST_W-1:0]    dst_row;
    logic [PIX_W-1:0]    pixel_out;
    logic                last;
    logic [STATUS_W-1:0] status;
  } blit_result_t;

  // register copies
  logic [ORG_W-1:0]  org_x, org_y;
  logic [SPAN_W-1:0] src_w, src_h, dst_w, dst_h;
  logic [PAIR_W-1:0] pair;

  // stepper state
  logic [ACC_W-1:0]  step_x, step_y, acc_x, acc_y;
  logic [SPAN_W-1:0] col_cnt, row_cnt;
  logic              walking;
  logic [PIX_W-1:0]  palette [PAL_DEPTH];

  blit_result_t results_due [$];
  int           mismatches = 0;
  int           due_count  = 0;

  assign fail_count  = mismatches;
  assign outstanding = due_count;

  function automatic logic [SPAN_W-1:0] cap_span(input logic [SPAN_W-1:0] v);
    if (int'(v) > MAX_DIM) return SPAN_W'(MAX_DIM);
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                 input logic [PIX_W-1:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    blit_result_t      want;
    blit_result_t      r;
    logic [SPAN_W-1:0] tw, th;
    if (!rst_n) begin
      org_x   = '0;
      org_y   = '0;
      src_w   = '0;
      src_h   = '0;
      dst_w   = '0;
      dst_h   = '0;
      pair    = PAIR_IDX_IDX;
      step_x  = '0;
      step_y  = '0;
      acc_x   = '0;
      acc_y   = '0;
      col_cnt = '0;
      row_cnt = '0;
      walking = 1'b0;
      results_due.delete();
    end else begin
      // results leave before this edge's command is predicted
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing due, status", PIX_W'(out_ch.status), '0);
        end else begin
          want = results_due.pop_front();
          if (out_ch.src_col !== want.src_col)
            report_mismatch("src_col", PIX_W'(out_ch.src_col), PIX_W'(want.src_col));
          if (out_ch.src_row !== want.src_row)
            report_mismatch("src_row", PIX_W'(out_ch.src_row), PIX_W'(want.src_row));
          if (out_ch.dst_col !== want.dst_col)
            report_mismatch("dst_col", PIX_W'(out_ch.dst_col), PIX_W'(want.dst_col));
          if (out_ch.dst_row !== want.dst_row)
            report_mismatch("dst_row", PIX_W'(out_ch.dst_row), PIX_W'(want.dst_row));
          if (out_ch.pixel_out !== want.pixel_out)
            report_mismatch("pixel_out", out_ch.pixel_out, want.pixel_out);
          if (out_ch.last !== want.last)
            report_mismatch("last", PIX_W'(out_ch.last), PIX_W'(want.last));
          if (out_ch.status !== want.status)
            report_mismatch("status", PIX_W'(out_ch.status), PIX_W'(want.status));
        end
      end

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          CFG_ORIGIN_X: org_x = cfg_ch.data[ORG_W-1:0];
          CFG_ORIGIN_Y: org_y = cfg_ch.data[ORG_W-1:0];
          CFG_SRC_W:    src_w = cfg_ch.data[SPAN_W-1:0];
          CFG_SRC_H:    src_h = cfg_ch.data[SPAN_W-1:0];
          CFG_DST_W:    dst_w = cfg_ch.data[SPAN_W-1:0];
          CFG_DST_H:    dst_h = cfg_ch.data[SPAN_W-1:0];
          CFG_PAIR:     pair  = cfg_ch.data[PAIR_W-1:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        r  = '0;
        tw = cap_span(dst_w);
        th = cap_span(dst_h);
        case (in_ch.mode)
          MODE_PAL_WR: palette[in_ch.palette_slot] = in_ch.palette_color;
          MODE_START: begin
            walking = 1'b0;
            col_cnt = '0;
            row_cnt = '0;
            acc_x   = '0;
            acc_y   = ACC_W'(org_y) << FRAC_BITS;
            if (pair == PAIR_ARGB_IDX) begin
              r.status = ST_BAD_PAIR;
              results_due.push_back(r);
            end else if (tw != 0 && th != 0) begin
              step_x  = ACC_W'((64'(cap_span(src_w)) << FRAC_BITS) / 64'(tw));
              step_y  = ACC_W'((64'(cap_span(src_h)) << FRAC_BITS) / 64'(th));
              walking = 1'b1;
            end
          end
          MODE_NEXT: begin
            if (!walking) begin
              r.status = ST_NO_BLIT;
            end else begin
              r.src_col = SRC_W'(ACC_W'(org_x) + (acc_x >> FRAC_BITS));
              r.src_row = SRC_W'(acc_y >> FRAC_BITS);
              r.dst_col = DST_W'(col_cnt);
              r.dst_row = DST_W'(row_cnt);
              r.last    = (ACC_W'(col_cnt) + 1 >= ACC_W'(tw)) &&
                          (ACC_W'(row_cnt) + 1 >= ACC_W'(th));
              if (r.last) begin
                walking = 1'b0;
              end else begin
                col_cnt = col_cnt + 1'b1;
                acc_x   = acc_x + step_x;
                if (col_cnt >= tw) begin
                  col_cnt = '0;
                  acc_x   = '0;
                  row_cnt = row_cnt + 1'b1;
                  acc_y   = acc_y + step_y;
                end
              end
            end
            results_due.push_back(r);
          end
          default: begin
            case (pair)
              PAIR_IDX_IDX:   r.pixel_out = PIX_W'(in_ch.pixel_in[7:0]);
              PAIR_ARGB_ARGB: r.pixel_out = in_ch.pixel_in;
              PAIR_IDX_ARGB:  r.pixel_out = palette[in_ch.pixel_in[7:0]];
              default:        r.status    = ST_BAD_PAIR;
            endcase
            results_due.push_back(r);
          end
        endcase
      end
    end
    due_count = results_due.size();
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the nearest-neighbor blit scaler
// Drives a short directed pass over the corner cases, then register settings
// of random shape, each followed by mostly exact blit walks with random noise
// mixed in. Both channels idle at random. A separate checker predicts and
// compares every result transfer.
// ----------------------------------------------------------------------------
module tb_top;
  import nnbs_pkg::*;

  localparam int RANDOM_ITEMS   = 1950;
  // start blit runs the divider twice, with no result
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   idle_cycles = 0;

  nnbs_in_if  in_ch ();
  nnbs_out_if out_ch ();
  nnbs_cfg_if cfg_ch ();

  nearest_neighbor_blit_scaler_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  blit_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_ch      (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // stimulus-side view of what the block holds
  int                items_sent = 0;
  int                gap_level  = 0;
  logic [PAIR_W-1:0] pair_now   = PAIR_IDX_IDX;
  logic [SPAN_W-1:0] walk_w     = '0;
  logic [SPAN_W-1:0] walk_h     = '0;
  logic [7:0]        filled_slots [$];
  bit                slot_filled [PAL_DEPTH];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // no transfer of any kind for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side backpressure. The stall level is redrawn periodically, and
  // level 0 gives long stretches with ready held high.
  initial begin : result_backpressure
    int stall;
    int level;
    int cycles;
    int r;
    stall        = 0;
    level        = 0;
    cycles       = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (cycles % 250 == 0) level = $urandom_range(0, 2);
      cycles++;
      if (stall == 0 && level != 0 && $urandom_range(0, 99) < (level == 1 ? 8 : 30)) begin
        r = $urandom_range(0, 99);
        if (r < 75)      stall = $urandom_range(1, 3);
        else if (r < 95) stall = $urandom_range(4, 12);
        else             stall = $urandom_range(20, 60);
      end
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // One command transfer. A random gap first, then the item is held until
  // ready. Valid stays high on return so back-to-back items need no dip.
  task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [7:0] slot,
                          input logic [PIX_W-1:0] color, input logic [PIX_W-1:0] pix);
    int gap;
    int r;
    if (items_sent % 150 == 0) gap_level = $urandom_range(0, 2);
    gap = 0;
    r   = $urandom_range(0, 99);
    if (gap_level != 0 && r >= (gap_level == 1 ? 60 : 25)) begin
      r = $urandom_range(0, 99);
      if (r < 75)      gap = $urandom_range(1, 3);
      else if (r < 96) gap = $urandom_range(4, 12);
      else             gap = $urandom_range(20, 50);
    end
    if (gap > 0) begin
      @(negedge clk) in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.mode          = mode;
    in_ch.palette_slot  = slot;
    in_ch.palette_color = color;
    in_ch.pixel_in      = pix;
    in_ch.valid         = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // start or next; the unused payload fields carry noise
  task automatic send_simple(input logic [MODE_W-1:0] mode);
    send_cmd(mode, 8'($urandom), $urandom, $urandom);
  endtask

  task automatic write_palette(input logic [7:0] slot, input logic [PIX_W-1:0] color);
    send_cmd(MODE_PAL_WR, slot, color, $urandom);
    if (!slot_filled[slot]) begin
      slot_filled[slot] = 1'b1;
      filled_slots.push_back(slot);
    end
  endtask

  task automatic send_convert(input logic [PIX_W-1:0] pix);
    send_cmd(MODE_CONVERT, 8'($urandom), $urandom, pix);
  endtask

  // Drop valid, let every due result drain, then cover the divider, which
  // can still be busy on a start that returns nothing.
  task automatic wait_idle();
    @(negedge clk) in_ch.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; now and then the bits above the field carry junk that
  // the block must drop.
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input int unsigned value);
    int unsigned       width;
    logic [CFG_DW-1:0] word;
    case (idx)
      CFG_ORIGIN_X, CFG_ORIGIN_Y: width = ORG_W;
      CFG_PAIR: begin
        width    = PAIR_W;
        pair_now = PAIR_W'(value);
      end
      CFG_DST_W: begin
        width  = SPAN_W;
        walk_w = SPAN_W'(value);
      end
      CFG_DST_H: begin
        width  = SPAN_W;
        walk_h = SPAN_W'(value);
      end
      default: width = SPAN_W;
    endcase
    word = CFG_DW'(value);
    if ($urandom_range(0, 3) == 0) word = word | CFG_DW'($urandom << width);
    @(negedge clk);
    cfg_ch.addr  = idx;
    cfg_ch.data  = word;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk) cfg_ch.valid = 1'b0;
  endtask

  task automatic apply_config(input int unsigned ox, input int unsigned oy,
                              input int unsigned sw, input int unsigned sh,
                              input int unsigned tw, input int unsigned th,
                              input logic [PAIR_W-1:0] pair);
    wait_idle();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_SRC_W, sw);
    write_reg(CFG_SRC_H, sh);
    write_reg(CFG_DST_W, tw);
    write_reg(CFG_DST_H, th);
    write_reg(CFG_PAIR, pair);
  endtask

  // Span pick: mostly small, with zero, the clamp point and values above it.
  function automatic int unsigned pick_span(input int unsigned usual_max);
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return MAX_DIM;
      2:       return 8191;
      3:       return $urandom_range(MAX_DIM + 1, 8191);
      4:       return $urandom_range(0, MAX_DIM - 1);
      default: return $urandom_range(1, usual_max);
    endcase
  endfunction

  // A stray command dropped into a walk: palette traffic, converts, extra
  // steps, or a restart that cuts the walk short.
  task automatic noise_item();
    logic [PIX_W-1:0] pix;
    pix = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: write_palette(8'($urandom), $urandom);
      3, 4, 5, 6: begin
        // an index through the palette only ever hits a written entry
        if (pair_now == PAIR_IDX_ARGB)
          pix[7:0] = filled_slots[$urandom_range(0, filled_slots.size() - 1)];
        send_convert(pix);
      end
      7, 8:    send_simple(MODE_NEXT);
      default: send_simple(MODE_START);
    endcase
  endtask

  initial begin : stimulus
    int                random_base;
    int                pixels;
    int                n;
    int                r;
    int unsigned       ox, oy;
    logic [PAIR_W-1:0] pair;
    logic [SPAN_W-1:0] cw, ch;
    bit                drained_once;

    drained_once        = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = MODE_PAL_WR;
    in_ch.palette_slot  = '0;
    in_ch.palette_color = '0;
    in_ch.pixel_in      = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.addr         = CFG_ORIGIN_X;
    cfg_ch.data         = '0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // ---- directed ----
    // far corner origin, source spans at and above the clamp, 2x2 target
    apply_config(4095, 4095, 8191, MAX_DIM, 2, 2, PAIR_IDX_ARGB);
    send_simple(MODE_NEXT);                 // nothing started yet
    write_palette(8'h00, 32'hFFFF_FFFF);
    write_palette(8'hFF, 32'h0000_0000);
    send_convert(32'hFFFF_FF00);            // lookup of entry 0
    send_convert(32'h0000_00FF);            // lookup of entry 255
    send_simple(MODE_START);
    repeat (4) send_simple(MODE_NEXT);      // last on the fourth pixel
    send_simple(MODE_NEXT);                 // walk is over
    send_simple(MODE_START);
    send_simple(MODE_NEXT);
    send_simple(MODE_START);                // restart in the middle of a walk
    repeat (4) send_simple(MODE_NEXT);

    // single pixel blit from an empty source, low byte pass
    apply_config(0, 0, 0, 0, 1, 1, PAIR_IDX_IDX);
    send_convert(32'hFFFF_FFFF);
    send_simple(MODE_START);
    send_simple(MODE_NEXT);

    wait_idle();
    write_reg(CFG_PAIR, PAIR_ARGB_ARGB);
    send_convert($urandom);

    // unsupported pair: start and convert both refuse, start leaves no walk
    wait_idle();
    write_reg(CFG_PAIR, PAIR_ARGB_IDX);
    send_convert($urandom);
    send_simple(MODE_START);
    send_simple(MODE_NEXT);

    // zero target height: start gives nothing and arms nothing
    apply_config(7, 9, 5, 3, 3, 0, PAIR_IDX_IDX);
    send_simple(MODE_START);
    send_simple(MODE_NEXT);

    // ---- random ----
    random_base = items_sent;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      r  = $urandom_range(0, 9);
      ox = (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(0, 4095);
      r  = $urandom_range(0, 9);
      oy = (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(0, 4095);
      r  = $urandom_range(0, 19);
      if (r < 3)      pair = PAIR_IDX_IDX;
      else if (r < 6) pair = PAIR_ARGB_ARGB;
      else if (r < 8) pair = PAIR_ARGB_IDX;
      else            pair = PAIR_IDX_ARGB;
      apply_config(ox, oy, pick_span(64), pick_span(64), pick_span(6), pick_span(5), pair);

      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 2)) noise_item();
        send_simple(MODE_START);
        cw     = (int'(walk_w) > MAX_DIM) ? SPAN_W'(MAX_DIM) : walk_w;
        ch     = (int'(walk_h) > MAX_DIM) ? SPAN_W'(MAX_DIM) : walk_h;
        pixels = (pair_now == PAIR_ARGB_IDX) ? 0 : int'(cw) * int'(ch);
        if (pixels == 0)     n = $urandom_range(1, 3);
        else if (pixels > 64) n = $urandom_range(8, 64);
        else                 n = pixels;
        // mostly exact walks; some stop short, some run past the end
        r = $urandom_range(0, 9);
        if (r == 0)      n = $urandom_range(1, n);
        else if (r == 1) n = n + $urandom_range(1, 2);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 11) == 0) noise_item();
          // once, hold the sender until the result queue is empty
          if (!drained_once && k == n / 2) begin
            wait_idle();
            drained_once = 1'b1;
          end
          send_simple(MODE_NEXT);
        end
      end
    end

    wait_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/nnbs_pkg.sv
rtl/nnbs_if.sv
rtl/nnbs_divider.sv
rtl/nnbs_palette.sv
rtl/nearest_neighbor_blit_scaler_core.sv
verif/blit_result_checker.sv
verif/tb_top.sv
